// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is active
`define HSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/hsg_pkg.sv -----
`default_nettype none

package hsg_pkg;

	localparam int CHANNELS = 80;
	localparam int SEQ_LEN  = 240;

	localparam int CH_W       = 7;
	localparam int FREQ_W     = 32;
	localparam int STEP_W     = 24;
	localparam int SEED_W     = 32;
	localparam int HOP_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam int IDX_W    = $clog2(SEQ_LEN);
	localparam int POS_W    = $clog2(CHANNELS);
	localparam int SYNC_CH  = CHANNELS / 2;
	localparam int CHAN_MOD = CHANNELS - 1;
	localparam int DIV_MAX  = (SEQ_LEN > CHAN_MOD) ? SEQ_LEN : CHAN_MOD;
	localparam int DIV_W    = $clog2(DIV_MAX + 1);
	localparam int TGT_W    = $clog2(SEQ_LEN + CHANNELS);
	localparam int PROD_W   = CH_W + STEP_W;

	// remainder unit: dividend width and bits retired per cycle
	localparam int REM_BITS  = 32;
	localparam int REM_RADIX = 8;
	localparam int REM_STEPS = REM_BITS / REM_RADIX;
	localparam int REM_CNT_W = $clog2(REM_STEPS);

	localparam logic [FREQ_W-1:0] BASE_RESET = 32'd2400400000;
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd1000000;

	typedef enum logic {
		OP_GEN    = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE = 1'b0,
		CFG_STEP = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		DIV_SEQ  = 1'b0,
		DIV_CHAN = 1'b1
	} div_sel_t;

	typedef enum logic [1:0] {
		RD_IDX = 2'd0,
		RD_TGT = 2'd1,
		RD_LK  = 2'd2
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SH_CHK,
		ST_SH_MOD,
		ST_SH_RDI,
		ST_SH_RDT,
		ST_SH_WRI,
		ST_SH_WRT,
		ST_LK_MOD,
		ST_LK_RD,
		ST_LK_MUL,
		ST_LK_OUT
	} state_t;

	typedef struct packed {
		logic    gen_start;
		logic    lk_start;
		logic    fill_wr;
		logic    adv;
		logic    draw;
		rd_sel_t rd_sel;
		logic    cap_tmp;
		logic    wr_i;
		logic    wr_t;
		logic    mul;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic rem_busy;
		logic idx_last;
		logic pos_zero;
		logic tgt_ok;
	} sts_t;

	function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] t;
		t = s ^ (s << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hsg_ram.sv -----
`default_nettype none

module hsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/core/hsg_rem.sv -----
`default_nettype none

// Restoring remainder, REM_RADIX dividend bits per cycle, MSB first.
module hsg_rem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire hsg_pkg::div_sel_t         sel,
	input  wire logic [hsg_pkg::REM_BITS-1:0] dividend,
	output logic                           busy,
	output logic [hsg_pkg::DIV_W-1:0]      rem
);

	import hsg_pkg::*;

	logic [REM_BITS-1:0]  dvd_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [REM_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIV_W-1:0]     rem_nxt;

	always_comb begin
		logic [DIV_W:0] r;
		r = {1'b0, rem_q};
		for (int j = 0; j < REM_RADIX; j++) begin
			r = {r[DIV_W-1:0], dvd_q[REM_BITS-1-j]};
			if (r >= {1'b0, dsr_q}) begin
				r = r - {1'b0, dsr_q};
			end
		end
		rem_nxt = r[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + REM_CNT_W'(1);
			if (cnt_q == REM_CNT_W'(REM_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= (sel == DIV_CHAN) ? DIV_W'(CHAN_MOD) : DIV_W'(SEQ_LEN);
		end else if (busy_q) begin
			dvd_q <= dvd_q << REM_RADIX;
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/hsg_datapath.sv -----
`default_nettype none

module hsg_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [hsg_pkg::SEED_W-1:0]    seed,
	input  wire logic [hsg_pkg::HOP_W-1:0]     hop_index,
	input  wire logic                          cfg_valid,
	input  wire logic [hsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hsg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire hsg_pkg::cmd_t                 cmd,
	output hsg_pkg::sts_t                      sts,
	output logic                               done,
	output logic [hsg_pkg::CH_W-1:0]           channel,
	output logic [hsg_pkg::FREQ_W-1:0]         frequency_hz
);

	import hsg_pkg::*;

	logic [FREQ_W-1:0] base_q;
	logic [STEP_W-1:0] step_q;
	logic [SEED_W-1:0] rng_q;
	logic [SEED_W-1:0] rng_nxt;
	logic              tbl_valid_q;

	logic [IDX_W-1:0]  idx_q;
	logic [POS_W-1:0]  pos_q;
	logic [IDX_W-1:0]  off_q;
	logic [CH_W-1:0]   tmp_q;

	logic [CH_W-1:0]   ch_s1;
	logic [PROD_W-1:0] prod_s1;

	logic              done_q;
	logic [CH_W-1:0]   channel_q;
	logic [FREQ_W-1:0] freq_q;

	logic              rem_start;
	div_sel_t          rem_sel;
	logic [REM_BITS-1:0] rem_dvd;
	logic              rem_busy;
	logic [DIV_W-1:0]  rem_val;

	logic [TGT_W-1:0]  tgt;
	logic [CH_W-1:0]   fill_val;
	logic [CH_W-1:0]   lk_ch;
	logic              idx_last;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CH_W-1:0]   wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [CH_W-1:0]   rd_data;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BASE: base_q <= cfg_data;
				CFG_STEP: step_q <= cfg_data[STEP_W-1:0];
				default:  ;
			endcase
		end
	end

	assign rng_nxt = xorshift32(rng_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q       <= '0;
			tbl_valid_q <= 1'b0;
		end else if (cmd.gen_start) begin
			rng_q       <= seed;
			tbl_valid_q <= 1'b1;
		end else if (cmd.draw) begin
			rng_q <= rng_nxt;
		end
	end

	// table walk: position within block and block offset track idx_q
	assign idx_last = (idx_q == IDX_W'(SEQ_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pos_q <= '0;
			off_q <= '0;
		end else if (cmd.gen_start || (cmd.adv && idx_last)) begin
			idx_q <= '0;
			pos_q <= '0;
			off_q <= '0;
		end else if (cmd.adv) begin
			idx_q <= idx_q + IDX_W'(1);
			if (pos_q == POS_W'(CHANNELS - 1)) begin
				pos_q <= '0;
				off_q <= idx_q + IDX_W'(1);
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_comb begin
		if (pos_q == '0) begin
			fill_val = CH_W'(SYNC_CH);
		end else if (pos_q == POS_W'(SYNC_CH)) begin
			fill_val = '0;
		end else begin
			fill_val = CH_W'(pos_q);
		end
	end

	// shared remainder unit: draw mod (CHANNELS-1), or hop index mod SEQ_LEN
	assign rem_start = cmd.draw | cmd.lk_start;
	assign rem_sel   = cmd.draw ? DIV_CHAN : DIV_SEQ;
	assign rem_dvd   = cmd.draw ? rng_nxt : REM_BITS'(hop_index);

	hsg_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.sel      (rem_sel),
		.dividend (rem_dvd),
		.busy     (rem_busy),
		.rem      (rem_val)
	);

	assign tgt = TGT_W'(off_q) + TGT_W'(rem_val) + TGT_W'(1);

	always_comb begin
		wr_en   = cmd.fill_wr | cmd.wr_i | cmd.wr_t;
		wr_addr = idx_q;
		wr_data = fill_val;
		if (cmd.wr_i) begin
			wr_data = rd_data;
		end else if (cmd.wr_t) begin
			wr_addr = tgt[IDX_W-1:0];
			wr_data = tmp_q;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_IDX:  rd_addr = idx_q;
			RD_TGT:  rd_addr = tgt[IDX_W-1:0];
			RD_LK:   rd_addr = rem_val[IDX_W-1:0];
			default: rd_addr = idx_q;
		endcase
	end

	hsg_ram #(
		.WIDTH (CH_W),
		.DEPTH (SEQ_LEN)
	) u_tbl (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_tmp) begin
			tmp_q <= rd_data;
		end
	end

	// table reads as zeros until the first generate rewrites it
	assign lk_ch = tbl_valid_q ? rd_data : '0;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			ch_s1   <= lk_ch;
			prod_s1 <= PROD_W'(lk_ch) * PROD_W'(step_q);
		end
		if (cmd.out_load) begin
			channel_q <= ch_s1;
			freq_q    <= base_q + FREQ_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out_load;
		end
	end

	assign sts.rem_busy = rem_busy;
	assign sts.idx_last = idx_last;
	assign sts.pos_zero = (pos_q == '0);
	assign sts.tgt_ok   = (tgt < TGT_W'(SEQ_LEN));

	assign done         = done_q;
	assign channel      = channel_q;
	assign frequency_hz = freq_q;

endmodule

`default_nettype wire

// ----- rtl/core/hsg_ctrl.sv -----
`default_nettype none

module hsg_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          opcode,
	input  wire hsg_pkg::sts_t sts,
	output logic               busy,
	output hsg_pkg::cmd_t      cmd
);

	import hsg_pkg::*;

	`include "assert_macros.svh"

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = (op_t'(opcode) == OP_GEN) ? ST_FILL : ST_LK_MOD;
				end
			end
			ST_FILL: begin
				if (sts.idx_last) state_nxt = ST_SH_CHK;
			end
			ST_SH_CHK: begin
				if (!sts.pos_zero) begin
					state_nxt = ST_SH_MOD;
				end else if (sts.idx_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SH_MOD: begin
				if (!sts.rem_busy) begin
					if (sts.tgt_ok) begin
						state_nxt = ST_SH_RDI;
					end else begin
						state_nxt = sts.idx_last ? ST_IDLE : ST_SH_CHK;
					end
				end
			end
			ST_SH_RDI: state_nxt = ST_SH_RDT;
			ST_SH_RDT: state_nxt = ST_SH_WRI;
			ST_SH_WRI: state_nxt = ST_SH_WRT;
			ST_SH_WRT: state_nxt = sts.idx_last ? ST_IDLE : ST_SH_CHK;
			ST_LK_MOD: begin
				if (!sts.rem_busy) state_nxt = ST_LK_RD;
			end
			ST_LK_RD:  state_nxt = ST_LK_MUL;
			ST_LK_MUL: state_nxt = ST_LK_OUT;
			ST_LK_OUT: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		cmd.rd_sel = RD_IDX;
		unique case (state_q)
			ST_IDLE: begin
				busy          = 1'b0;
				cmd.gen_start = start && (op_t'(opcode) == OP_GEN);
				cmd.lk_start  = start && (op_t'(opcode) == OP_LOOKUP);
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				cmd.adv     = 1'b1;
			end
			ST_SH_CHK: begin
				// slot 0 of a block is never swapped and draws nothing
				cmd.adv  = sts.pos_zero;
				cmd.draw = !sts.pos_zero;
			end
			ST_SH_MOD: begin
				// target past the table end: value drawn, swap skipped
				cmd.adv = !sts.rem_busy && !sts.tgt_ok;
			end
			ST_SH_RDI: cmd.rd_sel = RD_IDX;
			ST_SH_RDT: begin
				cmd.rd_sel  = RD_TGT;
				cmd.cap_tmp = 1'b1;
			end
			ST_SH_WRI: cmd.wr_i = 1'b1;
			ST_SH_WRT: begin
				cmd.wr_t = 1'b1;
				cmd.adv  = 1'b1;
			end
			ST_LK_MOD: ;
			ST_LK_RD:  cmd.rd_sel = RD_LK;
			ST_LK_MUL: cmd.mul = 1'b1;
			ST_LK_OUT: cmd.out_load = 1'b1;
			default:   ;
		endcase
	end

	`HSG_ASSERT_NEXT(a_busy_after_request, clk, arst_n, start && !busy, busy, "busy not raised after request")
	`HSG_ASSERT_NOW(a_rem_idle_on_start, clk, arst_n, cmd.draw || cmd.lk_start, !sts.rem_busy, "remainder unit restarted while busy")
	`HSG_ASSERT_NOW(a_swap_in_range, clk, arst_n, state_q == ST_SH_RDI, sts.tgt_ok, "swap target beyond table")
	`HSG_ASSERT_NOW(a_one_writer, clk, arst_n, 1'b1, $onehot0({cmd.fill_wr, cmd.wr_i, cmd.wr_t}), "table written from two sources")

endmodule

`default_nettype wire

// ----- rtl/core/hop_sequence_generator_top.sv -----
`default_nettype none

// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------
// request  | start / busy            | opcode, seed, hop_index
// result   | done (1-cycle strobe)   | channel, frequency_hz
// config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Lookup: done strobes after the remainder unit (8 bits per cycle), the
// registered table read and the multiply; the next request can be taken in
// the strobe cycle. Generate: the table is filled over its SEQ_LEN slots,
// then each slot is walked: a block-leading slot is passed over, any other
// draws a value and is swapped with its target unless that falls past the table.
// Reset clears config to its defaults; the table reads as zeros until a generate.
// The receiver cannot stall: done flags each result for one cycle only.
module hop_sequence_generator_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           opcode,
	input  wire logic [hsg_pkg::SEED_W-1:0]     seed,
	input  wire logic [hsg_pkg::HOP_W-1:0]      hop_index,
	output logic                                done,
	output logic [hsg_pkg::CH_W-1:0]            channel,
	output logic [hsg_pkg::FREQ_W-1:0]          frequency_hz,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [hsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hsg_pkg::CFG_DATA_W-1:0] cfg_data
);

	import hsg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	hsg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	hsg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed         (seed),
		.hop_index    (hop_index),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.channel      (channel),
		.frequency_hz (frequency_hz)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import hsg_pkg::*;

	localparam int SETTLE_CYCLES = 3000;    // outlasts the longest generate
	localparam int RUN_LIMIT     = 20000000;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 265;

	typedef enum logic {
		REQ_ITEM,
		REQ_CFG
	} req_kind_t;

	typedef struct {
		req_kind_t              kind;
		op_t                    op;
		logic [SEED_W-1:0]      seed;
		logic [HOP_W-1:0]       hop;
		cfg_reg_t               cfg_idx;
		logic [CFG_DATA_W-1:0]  data;
		int                     idle_pct;
	} hop_req_t;

	typedef struct {
		logic [CH_W-1:0]   ch;
		logic [FREQ_W-1:0] freq;
	} hop_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic                    opcode = OP_LOOKUP;
	logic [SEED_W-1:0]       seed = '0;
	logic [HOP_W-1:0]        hop_index = '0;
	logic                    done;
	logic [CH_W-1:0]         channel;
	logic [FREQ_W-1:0]       frequency_hz;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// hop table model, its generator and the frequency plan
	logic [CH_W-1:0]   hop_tbl [SEQ_LEN];
	logic [SEED_W-1:0] rng_word = '0;
	logic [FREQ_W-1:0] base_hz = BASE_RESET;
	logic [STEP_W-1:0] step_hz = STEP_RESET;

	hop_req_t    pend_reqs [$];
	hop_result_t due_hops [$];
	logic        owed = 1'b0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int unsigned run_cycles = 0;
	int          idle_by_phase [PHASES] = '{0, 67, 0, 34, 67, 0};

	hop_sequence_generator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.seed         (seed),
		.hop_index    (hop_index),
		.done         (done),
		.channel      (channel),
		.frequency_hz (frequency_hz),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < SEQ_LEN; i++)
			hop_tbl[i] = '0;
	end

	function automatic void rebuild_table(input logic [SEED_W-1:0] s);
		int unsigned i;
		int unsigned pos;
		int unsigned tgt;
		logic [CH_W-1:0] tmp;
		rng_word = s;
		for (i = 0; i < SEQ_LEN; i++) begin
			pos = i % CHANNELS;
			if (pos == 0)
				hop_tbl[i] = SYNC_CH[CH_W-1:0];
			else if (pos == SYNC_CH)
				hop_tbl[i] = '0;
			else
				hop_tbl[i] = pos[CH_W-1:0];
		end
		// leading slot of each block is never swapped and draws nothing
		for (i = 0; i < SEQ_LEN; i++) begin
			if (i % CHANNELS != 0) begin
				rng_word = rng_word ^ (rng_word << 13);
				rng_word = rng_word ^ (rng_word >> 17);
				rng_word = rng_word ^ (rng_word << 5);
				tgt = (i / CHANNELS) * CHANNELS + rng_word % CHAN_MOD + 1;
				if (tgt < SEQ_LEN) begin
					tmp = hop_tbl[i];
					hop_tbl[i] = hop_tbl[tgt];
					hop_tbl[tgt] = tmp;
				end
			end
		end
	endfunction

	function automatic hop_result_t lookup_hop(input logic [HOP_W-1:0] h);
		hop_result_t r;
		r.ch = hop_tbl[h % SEQ_LEN];
		r.freq = base_hz + {25'd0, r.ch} * {8'd0, step_hz};
		return r;
	endfunction

	function automatic void queue_lookup(input logic [HOP_W-1:0] h, input int pct);
		hop_req_t q;
		q.kind = REQ_ITEM;
		q.op = OP_LOOKUP;
		q.seed = $urandom;     // ignored by lookup
		q.hop = h;
		q.cfg_idx = CFG_BASE;
		q.data = '0;
		q.idle_pct = pct;
		pend_reqs.push_back(q);
	endfunction

	function automatic void queue_regen(input logic [SEED_W-1:0] s, input int pct);
		hop_req_t q;
		q.kind = REQ_ITEM;
		q.op = OP_GEN;
		q.seed = s;
		q.hop = 16'($urandom);  // ignored by generate
		q.cfg_idx = CFG_BASE;
		q.data = '0;
		q.idle_pct = pct;
		pend_reqs.push_back(q);
	endfunction

	function automatic void queue_cfg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
		hop_req_t q;
		q.kind = REQ_CFG;
		q.op = OP_LOOKUP;
		q.seed = '0;
		q.hop = '0;
		q.cfg_idx = r;
		q.data = d;
		q.idle_pct = 0;
		pend_reqs.push_back(q);
	endfunction

	always @(posedge clk) begin : drive
		logic took;
		logic held;
		took = start && !busy;
		held = (start && !took) || (cfg_valid && !cfg_ready);
		if (arst_n) begin
			if (took || (cfg_valid && cfg_ready))
				void'(pend_reqs.pop_front());
			quiet_cycles <= took ? 0 : quiet_cycles + 1;
			if (!held) begin
				if (pend_reqs.size() != 0 && pend_reqs[0].kind == REQ_ITEM &&
						$urandom_range(99) >= pend_reqs[0].idle_pct) begin
					start <= 1'b1;
					cfg_valid <= 1'b0;
					opcode <= pend_reqs[0].op;
					seed <= pend_reqs[0].seed;
					hop_index <= pend_reqs[0].hop;
				end else if (pend_reqs.size() != 0 && pend_reqs[0].kind == REQ_CFG &&
						!took && !owed && !busy && quiet_cycles >= SETTLE_CYCLES) begin
					// block is idle: no result owed, any generate long finished
					start <= 1'b0;
					cfg_valid <= 1'b1;
					cfg_index <= pend_reqs[0].cfg_idx;
					cfg_data <= pend_reqs[0].data;
				end else begin
					start <= 1'b0;
					cfg_valid <= 1'b0;
					opcode <= 1'($urandom);
					seed <= $urandom;
					hop_index <= 16'($urandom);
					cfg_data <= $urandom;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		hop_result_t want;
		if (arst_n) begin
			if (done) begin
				if (due_hops.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual channel %0d freq %0d",
						$time, channel, frequency_hz);
					mismatches++;
				end else begin
					want = due_hops.pop_front();
					if (channel !== want.ch) begin
						$display("%0t: channel mismatch: expected %0d, actual %0d",
							$time, want.ch, channel);
						mismatches++;
					end
					if (frequency_hz !== want.freq) begin
						$display("%0t: frequency_hz mismatch: expected %0d, actual %0d",
							$time, want.freq, frequency_hz);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BASE: base_hz = cfg_data;
					CFG_STEP: step_hz = cfg_data[STEP_W-1:0];
				endcase
			end
			if (start && !busy) begin
				if (opcode == OP_GEN)
					rebuild_table(seed);
				else
					due_hops.push_back(lookup_hop(hop_index));
			end
			owed <= (due_hops.size() != 0);
		end
	end

	always @(posedge clk) begin
		run_cycles <= run_cycles + 1;
		if (run_cycles >= RUN_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		int pct;
		int unsigned roll;

		// table still at reset: channel 0 at base frequency
		queue_lookup(16'd0, 0);
		queue_lookup(16'hFFFF, 0);
		queue_lookup(16'(SEQ_LEN - 1), 0);
		queue_lookup(16'(SEQ_LEN), 0);
		// zero seed: generator stuck at zero, every swap hits slot 1 of its block
		queue_regen(32'd0, 0);
		queue_lookup(16'd0, 0);
		queue_lookup(16'd1, 0);
		queue_lookup(16'(SYNC_CH), 0);
		queue_lookup(16'(CHANNELS - 1), 0);
		queue_lookup(16'(CHANNELS), 0);
		queue_lookup(16'(2 * CHANNELS), 0);
		queue_lookup(16'(SEQ_LEN - 1), 0);
		queue_regen(32'hFFFF_FFFF, 0);
		queue_lookup(16'd0, 0);
		queue_lookup(16'(SYNC_CH + 1), 0);
		queue_lookup(16'hFFFF, 0);
		queue_lookup(16'd200, 0);
		queue_regen(32'd1, 0);
		queue_lookup(16'd120, 0);
		queue_lookup(16'h8000, 0);
		queue_lookup(16'd80, 0);
		queue_regen(32'h8000_0000, 0);
		queue_lookup(16'd3, 0);
		queue_lookup(16'h7FFF, 0);

		for (phase = 0; phase < PHASES; phase++) begin
			pct = idle_by_phase[phase];
			case (phase)
				0: ;
				1: begin
					queue_cfg(CFG_BASE, 32'd0);
					queue_cfg(CFG_STEP, 32'd0);
				end
				2: begin
					queue_cfg(CFG_STEP, 32'hFFFF_FFFF);  // upper byte beyond the step width
					queue_cfg(CFG_BASE, 32'hFFFF_FFFF);
				end
				3: begin
					queue_cfg(CFG_BASE, $urandom);
					queue_cfg(CFG_STEP, $urandom);
				end
				4: begin
					queue_cfg(CFG_STEP, 32'd1);
					queue_cfg(CFG_BASE, $urandom);
				end
				default: begin
					queue_cfg(CFG_BASE, $urandom);
					queue_cfg(CFG_STEP, $urandom);
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(29);
				if (roll == 0)
					queue_regen(($urandom_range(9) == 0) ? 32'd0 : $urandom, pct);
				else if (roll < 15)
					queue_lookup(16'($urandom), pct);
				else
					queue_lookup(16'($urandom_range(SEQ_LEN - 1)), pct);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pend_reqs.size() != 0 || start || cfg_valid || owed);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (due_hops.size() != 0) begin
			$display("%0t: results missing: expected %0d more, actual 0",
				$time, due_hops.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/hsg_pkg.sv
rtl/core/hsg_ram.sv
rtl/core/hsg_rem.sv
rtl/core/hsg_datapath.sv
rtl/core/hsg_ctrl.sv
rtl/core/hop_sequence_generator_top.sv
tb/tb_top.sv
